@@ src/lzvn_pkg.sv @@
package lzvn_pkg;

  localparam int WIN_AW    = 16;          // history window address bits
  localparam int BPR       = 8;           // bytes per result
  localparam int LEN_W     = 9;           // run / match length bits
  localparam int DIST_W    = 16;
  localparam int CNT_W     = 4;
  localparam int FIFO_AW   = 2;           // command queue depth = 2**FIFO_AW
  localparam logic [31:0] LIMIT_RESET = 32'd65536;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_OP   = 3'd1;
  localparam logic [2:0] ST_BAD_DIST = 3'd2;
  localparam logic [2:0] ST_LIMIT    = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  // one decoded compressed byte: optional literal, then optional match
  typedef struct packed {
    logic              has_lit;
    logic [7:0]        lit;
    logic [LEN_W-1:0]  mlen;
    logic [DIST_W-1:0] distance;
    logic [2:0]        status;
    logic              ends;
  } cmd_t;

endpackage

@@ src/lzvn_front.sv @@
module lzvn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          byte_in,
  input  logic                byte_last,
  input  logic [31:0]         limit,
  output logic                push,
  output lzvn_pkg::cmd_t      cmd,
  input  logic                q_full
);

  typedef enum logic [2:0] {P_OP, P_ONE, P_FIRST, P_SECOND, P_LIT} phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [7:0]                       op_r, op_nxt, opd_r, opd_nxt;
  logic [lzvn_pkg::LEN_W-1:0]       lrem_r, lrem_nxt, mp_r, mp_nxt;
  logic [lzvn_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic [31:0]                      prod_r, prod_nxt;
  logic                             disc_r, disc_nxt;

  logic                             take, ended, start, run, c_lit;
  logic [2:0]                       st;
  logic [lzvn_pkg::LEN_W-1:0]       s_lit, s_match, len, c_mlen;
  logic [lzvn_pkg::DIST_W-1:0]      c_dist;
  logic [2:0]                       lo;

  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;
  assign lo         = byte_in[2:0];

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    opd_nxt   = opd_r;
    lrem_nxt  = lrem_r;
    mp_nxt    = mp_r;
    dist_nxt  = dist_r;
    prod_nxt  = prod_r;
    disc_nxt  = disc_r;
    st        = lzvn_pkg::ST_OK;
    ended     = 1'b0;
    start     = 1'b0;
    run       = 1'b0;
    c_lit     = 1'b0;
    c_mlen    = '0;
    c_dist    = '0;
    s_lit     = '0;
    s_match   = '0;
    len       = '0;
    if (take && disc_r) begin
      if (byte_last) begin
        phase_nxt = P_OP;
        op_nxt    = '0;
        opd_nxt   = '0;
        lrem_nxt  = '0;
        mp_nxt    = '0;
        dist_nxt  = '0;
        prod_nxt  = '0;
        disc_nxt  = 1'b0;
      end
    end else if (take) begin
      case (phase_r)
        P_OP: begin
          if (prod_r >= limit) begin
            ended = 1'b1;
          end else begin
            op_nxt = byte_in;
            if ((byte_in >= 8'h70 && byte_in <= 8'h7f) ||
                (byte_in >= 8'hd0 && byte_in <= 8'hdf)) begin
              st = lzvn_pkg::ST_BAD_OP;
            end else if (byte_in >= 8'ha0 && byte_in <= 8'hbf) begin
              phase_nxt = P_FIRST;
            end else if (byte_in == 8'he0 || byte_in == 8'hf0) begin
              phase_nxt = P_ONE;
            end else if (byte_in >= 8'he1 && byte_in <= 8'hef) begin
              start = 1'b1;
              s_lit = lzvn_pkg::LEN_W'(byte_in[3:0]);
            end else if (byte_in >= 8'hf1) begin
              mp_nxt = lzvn_pkg::LEN_W'(byte_in[3:0]);
              run    = 1'b1;
            end else if (lo == 3'd7) begin
              phase_nxt = P_FIRST;
            end else if (lo == 3'd6) begin
              if (byte_in >= 8'h40) begin
                start   = 1'b1;
                s_lit   = lzvn_pkg::LEN_W'(byte_in[7:6]);
                s_match = lzvn_pkg::LEN_W'(byte_in[5:3]) + lzvn_pkg::LEN_W'(3);
              end else if (byte_in == 8'h06) begin
                ended = 1'b1;                  // end-of-stream opcode
              end else if (byte_in != 8'h0e && byte_in != 8'h16) begin
                st = lzvn_pkg::ST_BAD_OP;      // no-ops pass quietly
              end
            end else begin
              phase_nxt = P_ONE;
            end
          end
        end
        P_ONE: begin
          if (op_r == 8'he0) begin
            start = 1'b1;
            s_lit = lzvn_pkg::LEN_W'(byte_in) + lzvn_pkg::LEN_W'(16);
          end else if (op_r == 8'hf0) begin
            mp_nxt = lzvn_pkg::LEN_W'(byte_in) + lzvn_pkg::LEN_W'(16);
            run    = 1'b1;
          end else begin
            dist_nxt = {5'd0, op_r[2:0], byte_in};
            start    = 1'b1;
            s_lit    = lzvn_pkg::LEN_W'(op_r[7:6]);
            s_match  = lzvn_pkg::LEN_W'(op_r[5:3]) + lzvn_pkg::LEN_W'(3);
          end
        end
        P_FIRST: begin
          opd_nxt   = byte_in;
          phase_nxt = P_SECOND;
        end
        P_SECOND: begin
          start = 1'b1;
          if (op_r >= 8'ha0 && op_r <= 8'hbf) begin
            dist_nxt = {2'd0, byte_in, opd_r[7:2]};
            s_lit    = lzvn_pkg::LEN_W'(op_r[4:3]);
            s_match  = lzvn_pkg::LEN_W'({op_r[2:0], opd_r[1:0]}) + lzvn_pkg::LEN_W'(3);
          end else begin
            dist_nxt = {byte_in, opd_r};
            s_lit    = lzvn_pkg::LEN_W'(op_r[7:6]);
            s_match  = lzvn_pkg::LEN_W'(op_r[5:3]) + lzvn_pkg::LEN_W'(3);
          end
        end
        P_LIT: begin
          c_lit    = 1'b1;
          prod_nxt = prod_r + 32'd1;
          if (lrem_r != '0) lrem_nxt = lrem_r - lzvn_pkg::LEN_W'(1);
          if (lrem_nxt == '0) run = 1'b1;
        end
        default: phase_nxt = P_OP;
      endcase

      if (start) begin
        mp_nxt = s_match;
        if (s_lit != '0) begin
          if ({1'b0, prod_nxt} + 33'(s_lit) > {1'b0, limit}) begin
            st = lzvn_pkg::ST_LIMIT;
          end else begin
            lrem_nxt  = s_lit;
            phase_nxt = P_LIT;
          end
        end else begin
          run = 1'b1;
        end
      end

      if (run) begin
        len       = mp_nxt;
        mp_nxt    = '0;
        phase_nxt = P_OP;
        if (len != '0) begin
          if (dist_nxt == '0 || 32'(dist_nxt) > prod_nxt) begin
            st = lzvn_pkg::ST_BAD_DIST;
          end else if ({1'b0, prod_nxt} + 33'(len) > {1'b0, limit}) begin
            st = lzvn_pkg::ST_LIMIT;
          end else begin
            c_mlen   = len;
            c_dist   = dist_nxt;       // taken before an end clears the state
            prod_nxt = prod_nxt + 32'(len);
          end
        end
      end

      if (st != lzvn_pkg::ST_OK) ended = 1'b1;
      if (!ended && byte_last) begin
        ended = 1'b1;
        st    = (phase_nxt != P_OP) ? lzvn_pkg::ST_TRUNC : lzvn_pkg::ST_OK;
      end
      if (ended) begin
        if (byte_last) begin
          phase_nxt = P_OP;
          op_nxt    = '0;
          opd_nxt   = '0;
          lrem_nxt  = '0;
          mp_nxt    = '0;
          dist_nxt  = '0;
          prod_nxt  = '0;
        end else begin
          disc_nxt = 1'b1;
        end
      end
    end
  end

  assign push         = take && !disc_r && (c_lit || c_mlen != '0 || ended);
  assign cmd.has_lit  = c_lit;
  assign cmd.lit      = byte_in;
  assign cmd.mlen     = c_mlen;
  assign cmd.distance = c_dist;
  assign cmd.status   = st;
  assign cmd.ends     = ended;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_OP;
      op_r    <= '0;
      opd_r   <= '0;
      lrem_r  <= '0;
      mp_r    <= '0;
      dist_r  <= '0;
      prod_r  <= '0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      opd_r   <= opd_nxt;
      lrem_r  <= lrem_nxt;
      mp_r    <= mp_nxt;
      dist_r  <= dist_nxt;
      prod_r  <= prod_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

@@ src/lzvn_cmd_fifo.sv @@
module lzvn_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzvn_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output lzvn_pkg::cmd_t rd_cmd,
  output logic           empty
);

  localparam int DEPTH = 2 ** lzvn_pkg::FIFO_AW;

  lzvn_pkg::cmd_t                 mem_r [DEPTH];
  logic [lzvn_pkg::FIFO_AW-1:0]   wp_r, rp_r;
  logic [lzvn_pkg::FIFO_AW:0]     cnt_r;

  assign full   = (cnt_r == (lzvn_pkg::FIFO_AW+1)'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (lzvn_pkg::FIFO_AW+1)'(push && !full)
                     - (lzvn_pkg::FIFO_AW+1)'(pop && !empty);
    end
  end

endmodule

@@ src/lzvn_back.sv @@
module lzvn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lzvn_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [8*lzvn_pkg::BPR-1:0]  out_bytes,
  output logic [lzvn_pkg::CNT_W-1:0]  out_count,
  output logic [2:0]                  out_status,
  output logic                        out_end,
  output logic [31:0]                 out_total,
  output logic                        out_run_last
);

  typedef enum logic [2:0] {S_IDLE, S_LIT, S_PRIME, S_COPY, S_END} state_t;

  localparam int WIN = 2 ** lzvn_pkg::WIN_AW;

  state_t                          state_r;
  lzvn_pkg::cmd_t                  cmd_r;
  logic [lzvn_pkg::LEN_W-1:0]      rem_r;
  logic [31:0]                     prod_r;
  logic [7:0]                      hist_r [lzvn_pkg::BPR];
  logic [8*lzvn_pkg::BPR-1:0]      acc_r;
  logic [lzvn_pkg::CNT_W-1:0]      cnt_r;
  logic [lzvn_pkg::WIN_AW-1:0]     rd_addr_r;
  logic [7:0]                      mem [WIN];
  logic [7:0]                      mem_q_r;

  logic                            can_emit, short_dist, we, re;
  logic [7:0]                      wd, cbyte;
  logic [lzvn_pkg::WIN_AW-1:0]     ra;
  logic [8*lzvn_pkg::BPR-1:0]      acc_new;

  assign can_emit   = !out_valid || out_ready;
  assign short_dist = cmd_r.distance <= lzvn_pkg::DIST_W'(lzvn_pkg::BPR);
  assign cbyte      = short_dist ? hist_r[3'(cmd_r.distance - 1'b1)] : mem_q_r;
  assign acc_new    = acc_r | ((8*lzvn_pkg::BPR)'(cbyte) << {cnt_r[2:0], 3'b000});
  assign q_pop      = (state_r == S_IDLE) && !q_empty;

  assign we = can_emit && (state_r == S_LIT || state_r == S_COPY);
  assign wd = (state_r == S_LIT) ? cmd_r.lit : cbyte;
  assign re = (state_r == S_PRIME) || (state_r == S_COPY && can_emit && !short_dist);
  assign ra = (state_r == S_PRIME) ?
              prod_r[lzvn_pkg::WIN_AW-1:0] - lzvn_pkg::WIN_AW'(cmd_r.distance) : rd_addr_r;

  always_ff @(posedge clk) begin
    if (we) mem[prod_r[lzvn_pkg::WIN_AW-1:0]] <= wd;
    if (re) mem_q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prod_r       <= '0;
      out_valid    <= 1'b0;
      cnt_r        <= '0;
      acc_r        <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (we) begin
        hist_r[0] <= wd;
        for (int i = 1; i < lzvn_pkg::BPR; i++) hist_r[i] <= hist_r[i-1];
      end
      if (re) rd_addr_r <= ra + 1'b1;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_cmd;
            rem_r <= q_cmd.mlen;
            cnt_r <= '0;
            acc_r <= '0;
            if (q_cmd.has_lit) state_r <= S_LIT;
            else if (q_cmd.mlen != '0)
              state_r <= (q_cmd.distance <= lzvn_pkg::DIST_W'(lzvn_pkg::BPR)) ?
                         S_COPY : S_PRIME;
            else state_r <= S_END;
          end
        end
        S_LIT: begin
          if (can_emit) begin
            out_valid    <= 1'b1;
            out_bytes    <= (8*lzvn_pkg::BPR)'(cmd_r.lit);
            out_count    <= lzvn_pkg::CNT_W'(1);
            out_total    <= prod_r + 32'd1;
            out_run_last <= (cmd_r.mlen == '0);
            out_status   <= (cmd_r.mlen == '0) ? cmd_r.status : lzvn_pkg::ST_OK;
            out_end      <= (cmd_r.mlen == '0) && cmd_r.ends;
            prod_r       <= prod_r + 32'd1;
            if (cmd_r.mlen != '0) begin
              state_r <= short_dist ? S_COPY : S_PRIME;
            end else begin
              state_r <= S_IDLE;
              if (cmd_r.ends) prod_r <= '0;
            end
          end
        end
        S_PRIME: state_r <= S_COPY;
        S_COPY: begin
          if (can_emit) begin
            prod_r <= prod_r + 32'd1;
            rem_r  <= rem_r - 1'b1;
            if (cnt_r == lzvn_pkg::CNT_W'(lzvn_pkg::BPR-1) || rem_r == lzvn_pkg::LEN_W'(1)) begin
              out_valid    <= 1'b1;
              out_bytes    <= acc_new;
              out_count    <= cnt_r + 1'b1;
              out_total    <= prod_r + 32'd1;
              out_run_last <= (rem_r == lzvn_pkg::LEN_W'(1));
              out_status   <= (rem_r == lzvn_pkg::LEN_W'(1)) ? cmd_r.status : lzvn_pkg::ST_OK;
              out_end      <= (rem_r == lzvn_pkg::LEN_W'(1)) && cmd_r.ends;
              cnt_r        <= '0;
              acc_r        <= '0;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              acc_r <= acc_new;
            end
            if (rem_r == lzvn_pkg::LEN_W'(1)) begin
              state_r <= S_IDLE;
              if (cmd_r.ends) prod_r <= '0;
            end
          end
        end
        S_END: begin
          if (can_emit) begin
            out_valid    <= 1'b1;
            out_bytes    <= '0;
            out_count    <= '0;
            out_total    <= prod_r;
            out_run_last <= 1'b1;
            out_status   <= cmd_r.status;
            out_end      <= 1'b1;
            prod_r       <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= lzvn_pkg::CNT_W'(lzvn_pkg::BPR))
    else $error("result byte count above width");
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |-> (out_end && out_run_last))
    else $error("empty result that does not end the stream");
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (rem_r != '0 && cmd_r.distance != '0))
    else $error("copy with no length or zero distance");

endmodule

@@ src/lzvn_stream_decompressor_core.sv @@
// LZVN stream decompressor: one compressed byte enters per in_ beat (in_tlast
// closes a stream), decoded data leaves as out_ beats of up to eight bytes.
// The front decoder parses opcodes and operands, checks distances and the
// output limit (cfg_wr_data, reset 65536) and queues at most one command per
// byte into a four-entry queue; the back end writes literals and copies
// matches from a 64 KiB history RAM. Every queued command is dispatched from
// the back end's idle state; after it a literal is written, and a match is
// copied byte by byte, after a RAM priming step when the distance is above
// eight; distances up to eight come from a small byte history so
// overlapping copies work. Opcode and operand bytes are taken at one per
// cycle while the queue has room. Each out_ beat carries
// status/stream_end in out_tuser on the last beat of the byte that ended the
// stream, and out_tlast marks the last beat caused by one input byte. After
// an error the rest of the stream is dropped up to in_tlast.
module lzvn_stream_decompressor_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,     // in_byte[7:0]
  input  logic          in_tlast,     // in_last
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,    // out_bytes[63:0], out_count[67:64],
                                      // produced_total[99:68], zero pad
  output logic [3:0]    out_tuser,    // status[2:0], stream_end[3]
  output logic          out_tlast,    // run_last
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data   // output_limit
);

  logic [31:0]     limit_r;
  logic            push, full, pop, empty;
  lzvn_pkg::cmd_t  wr_cmd, rd_cmd;
  logic [63:0]     bytes;
  logic [3:0]      count;
  logic [2:0]      status;
  logic            send;
  logic [31:0]     total;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= lzvn_pkg::LIMIT_RESET;
    else if (cfg_wr_en) limit_r <= cfg_wr_data;
  end

  lzvn_front u_front (
    .clk(clk), .rst_n(rst_n),
    .byte_valid(in_tvalid), .byte_ready(in_tready),
    .byte_in(in_tdata), .byte_last(in_tlast),
    .limit(limit_r), .push(push), .cmd(wr_cmd), .q_full(full)
  );

  lzvn_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_cmd(wr_cmd), .full(full),
    .pop(pop), .rd_cmd(rd_cmd), .empty(empty)
  );

  lzvn_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(empty), .q_cmd(rd_cmd), .q_pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_bytes(bytes), .out_count(count), .out_status(status),
    .out_end(send), .out_total(total), .out_run_last(out_tlast)
  );

  assign out_tdata = {4'd0, total, count, bytes};
  assign out_tuser = {send, status};

endmodule
